/* hw/rtl/csws_pkg.sv */
package csws_pkg;

  // Store geometry
  localparam int LAST_LINE  = 160;
  localparam int LINE_DEPTH = LAST_LINE + 1;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // Field widths
  localparam int COORD_W  = 10;
  localparam int RADIUS_W = 8;
  localparam int INDEX_W  = 8;
  localparam int EDGE_W   = 8;
  localparam int ENTRY_W  = 2 * EDGE_W;
  localparam int EDGE_MAX = 255;

  // Working widths: center +/- radius, walk error term
  localparam int ROW_W = 12;
  localparam int ERR_W = 12;

  // Command and reply codes
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REPLY_DRAW = 1'b0;
  localparam logic REPLY_READ = 1'b1;

endpackage

/* hw/rtl/csws_ram.sv */
module csws_ram #(
  parameter int Width = 16,
  parameter int Depth = 161
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/circle_scanline_window_spans_unit.sv */
// Circle scanline window store.
//
// Command channel: a word is taken at a rising edge with start_i high and
// busy_o low. command_i selects a circle draw (center_x_i, center_y_i,
// radius_i) or the read of one line entry (line_index_i).
// Result channel: valid_o is high for exactly one cycle per command and the
// word on reply_kind_o, left_edge_o, right_edge_o is taken at the edge that
// ends that cycle. Nothing on the result side can stall the block.
//
// Timing: a read is taken into the line store's registered read port at
// acceptance, and its result word is registered from ST_READ. A draw runs the
// midpoint walk with one line-store write port, one span per cycle, four spans
// per walk step, plus a final loop test; a draw takes about radius/1.41 + 1 walk steps (182 at radius 255).
// busy_o stays high from acceptance until the result cycle; the next command
// may be taken during the result cycle. One command is in work at a time.
//
// Reset: the per-line valid flags clear at once, so every line reads as zero
// right after reset; no clearing pass is needed and the block can take a
// command as soon as reset is released.
module circle_scanline_window_spans_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                command_i,
  input  logic signed [csws_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [csws_pkg::COORD_W-1:0] center_y_i,
  input  logic [csws_pkg::RADIUS_W-1:0]       radius_i,
  input  logic [csws_pkg::INDEX_W-1:0]        line_index_i,
  output logic                                valid_o,
  output logic                                reply_kind_o,
  output logic [csws_pkg::EDGE_W-1:0]         left_edge_o,
  output logic [csws_pkg::EDGE_W-1:0]         right_edge_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ
  } state_e;

  localparam int RW = csws_pkg::ROW_W;
  localparam int EW = csws_pkg::ERR_W;
  localparam int AW = csws_pkg::LINE_AW;

  state_e state_q, state_d;
  logic [1:0] phase_q, phase_d;

  logic signed [RW-1:0] cx_q, cx_d;
  logic signed [RW-1:0] cy_q, cy_d;
  logic signed [RW-1:0] xy_q, xy_d;
  logic signed [RW-1:0] yx_q, yx_d;
  logic signed [EW-1:0] err_q, err_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic                 idx_ok_q, idx_ok_d;

  logic                 line_valid_q [csws_pkg::LINE_DEPTH];

  logic                            res_valid_q, res_valid_d;
  logic                            kind_q, kind_d;
  logic [csws_pkg::EDGE_W-1:0]     left_q, left_d;
  logic [csws_pkg::EDGE_W-1:0]     right_q, right_d;

  logic                            accept;
  logic                            read_in_range;
  logic signed [RW-1:0]            row;
  logic signed [RW-1:0]            span_l;
  logic signed [RW-1:0]            span_r;
  logic                            row_ok;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [csws_pkg::ENTRY_W-1:0]    ram_wdata;
  logic                            ram_re;
  logic [csws_pkg::ENTRY_W-1:0]    ram_rdata;
  logic signed [EW-1:0]            err_step;

  function automatic logic [csws_pkg::EDGE_W-1:0] clamp_edge(logic signed [RW-1:0] e);
    logic [csws_pkg::EDGE_W-1:0] r;
    if (e < 0) begin
      r = '0;
    end else if (e > RW'(csws_pkg::EDGE_MAX)) begin
      r = csws_pkg::EDGE_W'(csws_pkg::EDGE_MAX);
    end else begin
      r = e[csws_pkg::EDGE_W-1:0];
    end
    return r;
  endfunction

  assign accept        = start_i && (state_q == ST_IDLE);
  assign read_in_range = {1'b0, line_index_i} <= (csws_pkg::INDEX_W + 1)'(csws_pkg::LAST_LINE);

  // Span for the current quadrant pair
  always_comb begin
    unique case (phase_q)
      2'd0: begin
        row    = cy_q - yx_q;
        span_l = cx_q - xy_q;
        span_r = cx_q + xy_q;
      end
      2'd1: begin
        row    = cy_q + yx_q;
        span_l = cx_q - xy_q;
        span_r = cx_q + xy_q;
      end
      2'd2: begin
        row    = cy_q - xy_q;
        span_l = cx_q - yx_q;
        span_r = cx_q + yx_q;
      end
      default: begin
        row    = cy_q + xy_q;
        span_l = cx_q - yx_q;
        span_r = cx_q + yx_q;
      end
    endcase
  end

  assign row_ok    = (row >= 0) && (row <= RW'(csws_pkg::LAST_LINE));
  assign ram_we    = (state_q == ST_WALK) && (xy_q >= yx_q) && row_ok;
  assign ram_waddr = row[AW-1:0];
  assign ram_wdata = {clamp_edge(span_l), clamp_edge(span_r)};
  assign ram_re    = accept && (command_i == csws_pkg::CMD_READ) && read_in_range;
  assign err_step  = err_q - ((EW'(yx_q) <<< 1) - EW'(1));

  csws_ram #(
    .Width(csws_pkg::ENTRY_W),
    .Depth(csws_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(AW'(line_index_i)),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    xy_d        = xy_q;
    yx_d        = yx_q;
    err_d       = err_q;
    idx_d       = idx_q;
    idx_ok_d    = idx_ok_q;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    left_d      = left_q;
    right_d     = right_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == csws_pkg::CMD_DRAW) begin
            cx_d    = RW'(center_x_i);
            cy_d    = RW'(center_y_i);
            xy_d    = RW'({1'b0, radius_i});
            yx_d    = '0;
            err_d   = EW'({1'b0, radius_i});
            phase_d = 2'd0;
            state_d = ST_WALK;
          end else begin
            idx_d    = AW'(line_index_i);
            idx_ok_d = read_in_range;
            state_d  = ST_READ;
          end
        end
      end
      ST_WALK: begin
        if ((phase_q == 2'd0) && (xy_q < yx_q)) begin
          // walk over: report the finished draw
          res_valid_d = 1'b1;
          kind_d      = csws_pkg::REPLY_DRAW;
          left_d      = '0;
          right_d     = '0;
          state_d     = ST_IDLE;
        end else begin
          phase_d = phase_q + 2'd1;
          if (phase_q == 2'd3) begin
            yx_d = yx_q + RW'(1);
            if (err_step < 0) begin
              err_d = err_step + ((EW'(xy_q) - EW'(1)) <<< 1);
              xy_d  = xy_q - RW'(1);
            end else begin
              err_d = err_step;
            end
          end
        end
      end
      ST_READ: begin
        res_valid_d = 1'b1;
        kind_d      = csws_pkg::REPLY_READ;
        if (idx_ok_q && line_valid_q[idx_q]) begin
          left_d  = ram_rdata[csws_pkg::ENTRY_W-1:csws_pkg::EDGE_W];
          right_d = ram_rdata[csws_pkg::EDGE_W-1:0];
        end else begin
          left_d  = '0;
          right_d = '0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      xy_q        <= '0;
      yx_q        <= '0;
      err_q       <= '0;
      idx_q       <= '0;
      idx_ok_q    <= 1'b0;
      res_valid_q <= 1'b0;
      kind_q      <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      for (int i = 0; i < csws_pkg::LINE_DEPTH; i++) begin
        line_valid_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      xy_q        <= xy_d;
      yx_q        <= yx_d;
      err_q       <= err_d;
      idx_q       <= idx_d;
      idx_ok_q    <= idx_ok_d;
      res_valid_q <= res_valid_d;
      kind_q      <= kind_d;
      left_q      <= left_d;
      right_q     <= right_d;
      if (ram_we) begin
        line_valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = res_valid_q;
  assign reply_kind_o = kind_q;
  assign left_edge_o  = left_q;
  assign right_edge_o = right_q;

`ifndef NO_ASSERTIONS
  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result without a command in work");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !valid_o))
    else $error("accepted word did not start work");

  a_write_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_WALK) && row_ok))
    else $error("line store written outside the walk");

  a_draw_reply_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (reply_kind_o == csws_pkg::REPLY_DRAW)) |->
      ((left_edge_o == '0) && (right_edge_o == '0)))
    else $error("draw reply carries edges");
`endif

endmodule

/* bench/span_store_checker.sv */
module span_store_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic                                command_i,
  input  logic signed [csws_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [csws_pkg::COORD_W-1:0] center_y_i,
  input  logic [csws_pkg::RADIUS_W-1:0]       radius_i,
  input  logic [csws_pkg::INDEX_W-1:0]        line_index_i,
  input  logic                                valid_i,
  input  logic                                reply_kind_i,
  input  logic [csws_pkg::EDGE_W-1:0]         left_edge_i,
  input  logic [csws_pkg::EDGE_W-1:0]         right_edge_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import csws_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] right;
  } span_reply_t;

  logic [ENTRY_W-1:0] line_model [0:LAST_LINE];
  span_reply_t        pending_replies [$];
  int                 mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [EDGE_W-1:0] clamp_edge(int e);
    if (e < 0) return '0;
    if (e > EDGE_MAX) return EDGE_W'(EDGE_MAX);
    return EDGE_W'(e);
  endfunction

  function automatic void store_span(int row, int lft, int rgt);
    // rows outside the store are dropped
    if (row < 0 || row > LAST_LINE) return;
    line_model[row] = {clamp_edge(lft), clamp_edge(rgt)};
  endfunction

  function automatic void trace_circle(int cx, int cy, int rad);
    int xy;
    int err;
    int yx;
    xy  = rad;
    err = rad;
    yx  = 0;
    while (xy >= yx) begin
      store_span(cy - yx, cx - xy, cx + xy);
      store_span(cy + yx, cx - xy, cx + xy);
      store_span(cy - xy, cx - yx, cx + yx);
      store_span(cy + xy, cx - yx, cx + yx);
      err -= 2 * yx - 1;
      yx++;
      if (err < 0) begin
        err += 2 * (xy - 1);
        xy--;
      end
    end
  endfunction

  function automatic span_reply_t predict_reply(logic cmd, int cx, int cy, int rad, int idx);
    span_reply_t r;
    if (cmd == CMD_DRAW) begin
      trace_circle(cx, cy, rad);
      r = '{kind: REPLY_DRAW, left: '0, right: '0};
    end else begin
      r.kind = REPLY_READ;
      {r.left, r.right} = (idx <= LAST_LINE) ? line_model[idx] : '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    span_reply_t want;
    if (!rst_ni) begin
      foreach (line_model[i]) line_model[i] = '0;
      pending_replies.delete();
      pending_o <= 0;
    end else begin
      // check the word leaving the block before queueing a new command
      if (valid_i) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("reply with no command pending", reply_kind_i, -1);
        end else begin
          want = pending_replies.pop_front();
          if (reply_kind_i !== want.kind) report_mismatch("reply_kind", reply_kind_i, want.kind);
          if (left_edge_i !== want.left) report_mismatch("left_edge", left_edge_i, want.left);
          if (right_edge_i !== want.right) report_mismatch("right_edge", right_edge_i, want.right);
        end
      end
      if (start_i && !busy_i) begin
        pending_replies.push_back(predict_reply(command_i, int'(center_x_i), int'(center_y_i),
                                                int'(radius_i), int'(line_index_i)));
      end
      pending_o <= pending_replies.size();
    end
  end

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csws_pkg::*;

  localparam int NUM_ITEMS    = 1000;
  localparam int DRAIN_CYCLES = 800;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       command = CMD_READ;
  logic signed [COORD_W-1:0]  center_x = '0;
  logic signed [COORD_W-1:0]  center_y = '0;
  logic [RADIUS_W-1:0]        radius = '0;
  logic [INDEX_W-1:0]         line_index = '0;
  logic                       valid;
  logic                       reply_kind;
  logic [EDGE_W-1:0]          left_edge;
  logic [EDGE_W-1:0]          right_edge;
  int                         fail_count;
  int                         pending;
  int                         items_sent = 0;

  always #5 clk = ~clk;

  circle_scanline_window_spans_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .command_i    (command),
    .center_x_i   (center_x),
    .center_y_i   (center_y),
    .radius_i     (radius),
    .line_index_i (line_index),
    .valid_o      (valid),
    .reply_kind_o (reply_kind),
    .left_edge_o  (left_edge),
    .right_edge_o (right_edge)
  );

  span_store_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .command_i    (command),
    .center_x_i   (center_x),
    .center_y_i   (center_y),
    .radius_i     (radius),
    .line_index_i (line_index),
    .valid_i      (valid),
    .reply_kind_i (reply_kind),
    .left_edge_i  (left_edge),
    .right_edge_i (right_edge),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Present one command word and hold it until the block takes it.
  task automatic send_cmd(logic cmd, int cx, int cy, int rad, int idx);
    start      <= 1'b1;
    command    <= cmd;
    center_x   <= COORD_W'(cx);
    center_y   <= COORD_W'(cy);
    radius     <= RADIUS_W'(rad);
    line_index <= INDEX_W'(idx);
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_draw(int cx, int cy, int rad);
    send_cmd(CMD_DRAW, cx, cy, rad, $urandom_range(0, 255));
  endtask

  task automatic send_read(int idx);
    send_cmd(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 255), idx);
  endtask

  function automatic int pick_radius();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(0, 40);
    if (sel < 95) return $urandom_range(0, 255);
    return 255;
  endfunction

  // Draw a circle that mostly lands on the store, then probe rows it touched.
  task automatic draw_and_probe();
    int cx;
    int cy;
    int rad;
    int row;
    int probes;
    cx     = $urandom_range(0, 400) - 100;
    cy     = $urandom_range(0, 240) - 40;
    rad    = pick_radius();
    probes = $urandom_range(1, 5);
    send_draw(cx, cy, rad);
    repeat (probes) begin
      row = cy - rad + $urandom_range(0, 2 * rad);
      if (row < 0 || row > 255) row = $urandom_range(0, LAST_LINE);
      send_read(row);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int burst_left;
    int gap;
    int sel;
    bit drained_once;
    burst_left   = 0;
    drained_once = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, both ends and past the end
    send_read(0);
    send_read(LAST_LINE);
    send_read(LAST_LINE + 1);
    send_read(255);
    // radius zero writes one pixel
    send_draw(100, 5, 0);
    send_read(5);
    // circles entirely off the store
    send_draw(-512, -512, 255);
    send_draw(511, 511, 255);
    send_read(0);
    // edges clamped high, then low, then both
    send_draw(511, 80, 255);
    send_read(80);
    send_draw(-512, 80, 255);
    send_read(80);
    send_read(LAST_LINE);
    send_draw(128, 80, 200);
    send_read(0);
    send_read(80);
    send_read(LAST_LINE);
    // partly off the top and bottom rows
    send_draw(-1, -1, 1);
    send_read(0);
    send_draw(300, LAST_LINE, 10);
    send_read(LAST_LINE);
    send_read(LAST_LINE - 5);

    while (items_sent < NUM_ITEMS) begin
      if (!drained_once && items_sent >= NUM_ITEMS / 2) begin
        hold_until_drained();
        drained_once = 1;
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        draw_and_probe();
      end else if (sel < 85) begin
        send_read($urandom_range(0, 255));
      end else begin
        send_draw($urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512, pick_radius());
      end
      burst_left--;
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
